[rtl/cbad_pkg.sv]
// Shared types and constants for the console bus address decoder.
package cbad_pkg;

  // Access kinds carried in the input item.
  typedef enum logic [2:0] {
    KIND_CPU_READ  = 3'd0,
    KIND_CPU_WRITE = 3'd1,
    KIND_CPU_PEEK  = 3'd2,
    KIND_PPU_READ  = 3'd3,
    KIND_PPU_WRITE = 3'd4,
    KIND_PPU_PEEK  = 3'd5
  } kind_e;

  // Devices an access can reach.
  typedef enum logic [3:0] {
    TGT_RAM     = 4'd0,
    TGT_PPUREG  = 4'd1,
    TGT_CTRL    = 4'd2,
    TGT_APU     = 4'd3,
    TGT_DMA     = 4'd4,
    TGT_PRGRAM  = 4'd5,
    TGT_PRGROM  = 4'd6,
    TGT_MAPPER  = 4'd7,
    TGT_NONE    = 4'd8,
    TGT_CHRRAM  = 4'd9,
    TGT_CHRROM  = 4'd10,
    TGT_VRAM    = 4'd11
  } target_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PRG_BANK_LOW  = 3'd0,
    CFG_PRG_BANK_HIGH = 3'd1,
    CFG_CHR_BANK_LOW  = 3'd2,
    CFG_CHR_BANK_HIGH = 3'd3,
    CFG_CHR_IS_RAM    = 3'd4,
    CFG_PRG_ROM_UNITS = 3'd5,
    CFG_NT_MODE       = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned OffsetW  = 23;

  // Nametable mirroring modes (other codes: no mirroring).
  localparam logic [1:0] NT_HORIZONTAL = 2'd0;
  localparam logic [1:0] NT_VERTICAL   = 2'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    target_e             target;
    logic [OffsetW-1:0]  offset;
    logic [7:0]          data_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] prg_bank_low;
    logic [7:0] prg_bank_high;
    logic [7:0] chr_bank_low;
    logic [7:0] chr_bank_high;
    logic       chr_is_ram;
    logic [7:0] prg_rom_units;
    logic [1:0] nametable_mode;
  } cfg_t;

endpackage

[rtl/console_bus_address_decoder.sv]
// Top level of the console bus address decoder: item pipeline and config registers.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries one CPU or PPU
// bus access per item: kind, 16-bit address and write byte.
// Output channel (out_valid_o / out_stall_i / out_item_o) returns one item per
// access: target device, offset within it and the write byte for writes.
// Items move on a rising edge with valid high and stall low.
// Pipeline: input register -> decode logic -> output register. An accepted item
// is held in the input register and its decoded result is loaded into the output
// register when that one is empty or drained; throughput is one item per cycle
// without stalls, set by the single pass through the decode between the registers.
// When the receiver stalls, the output item holds; the input register still
// drains into the output register whenever that one is empty, so the input is
// stalled only when both registers hold items and the output is stalled.
// Config writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered; an index past
// the last register is ignored. The user must make writes only while idle;
// the block does not enforce it. Reset empties both stages and restores the config
// defaults: banks 0, CHR ROM, one 16 KB PRG unit, no nametable mirroring.
module console_bus_address_decoder import cbad_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      out_load, in_load;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_bank_low   <= 8'd0;
      cfg_q.prg_bank_high  <= 8'd0;
      cfg_q.chr_bank_low   <= 8'd0;
      cfg_q.chr_bank_high  <= 8'd0;
      cfg_q.chr_is_ram     <= 1'b0;
      cfg_q.prg_rom_units  <= 8'd1;
      cfg_q.nametable_mode <= 2'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PRG_BANK_LOW:  cfg_q.prg_bank_low   <= cfg_data_i;
        CFG_PRG_BANK_HIGH: cfg_q.prg_bank_high  <= cfg_data_i;
        CFG_CHR_BANK_LOW:  cfg_q.chr_bank_low   <= cfg_data_i;
        CFG_CHR_BANK_HIGH: cfg_q.chr_bank_high  <= cfg_data_i;
        CFG_CHR_IS_RAM:    cfg_q.chr_is_ram     <= cfg_data_i[0];
        CFG_PRG_ROM_UNITS: cfg_q.prg_rom_units  <= cfg_data_i;
        CFG_NT_MODE:       cfg_q.nametable_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: output register loads when empty or being drained
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_item_i;
    end
    if (out_load && in_valid_q) begin
      out_q <= out_d;
    end
  end

  cbad_decode #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_decode (
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .result_o(out_d)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/cbad_decode.sv]
// Combinational CPU and PPU address map decode for one bus access.
module cbad_decode import cbad_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 16
) (
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam logic [OffsetW-1:0] HdrOff = OffsetW'(HEADER_BYTES);

  logic [15:0]        a;
  logic [13:0]        pa;
  logic [11:0]        nt_rel;
  logic [11:0]        nt_mir;
  logic [OffsetW-1:0] prg_low_off, prg_high_off;
  logic [OffsetW-1:0] chr_base, chr_low_off, chr_high_off;

  target_e            cpu_tgt, ppu_tgt, tgt;
  logic [OffsetW-1:0] cpu_off, ppu_off, off;
  logic               ppu_peek;

  assign a  = item_i.bus_address;
  assign pa = a[13:0];

  // ROM offsets into the cartridge image, header included
  assign prg_low_off  = HdrOff + {1'b0, cfg_i.prg_bank_low, a[13:0]};
  assign prg_high_off = HdrOff + {1'b0, cfg_i.prg_bank_high, a[13:0]};
  assign chr_base     = HdrOff + {1'b0, cfg_i.prg_rom_units, 14'd0};
  assign chr_low_off  = chr_base + {3'd0, cfg_i.chr_bank_low, pa[11:0]};
  assign chr_high_off = chr_base + {3'd0, cfg_i.chr_bank_high, pa[11:0]};

  // Nametable mirroring, applied on peeks below 0x3000 only
  assign nt_rel = pa[11:0];
  always_comb begin
    if (cfg_i.nametable_mode == NT_HORIZONTAL) begin
      nt_mir = {nt_rel[11], 1'b0, nt_rel[9:0]};
    end else if (cfg_i.nametable_mode == NT_VERTICAL) begin
      nt_mir = {1'b0, nt_rel[10:0]};
    end else begin
      nt_mir = nt_rel;
    end
  end

  // Plain CPU map (peeks and fall-through)
  always_comb begin
    cpu_tgt = TGT_NONE;
    cpu_off = '0;
    priority if (a < 16'h2000) begin
      cpu_tgt = TGT_RAM;
      cpu_off = OffsetW'(a[10:0]);
    end else if (a < 16'h4000) begin
      cpu_tgt = TGT_PPUREG;
      cpu_off = OffsetW'(a[2:0]);
    end else if (a == 16'h4016) begin
      cpu_tgt = TGT_CTRL;
    end else if (a < 16'h4018) begin
      cpu_tgt = TGT_APU;
      cpu_off = OffsetW'(a[4:0]);
    end else if (a >= 16'h6000 && a < 16'h8000) begin
      cpu_tgt = TGT_PRGRAM;
      cpu_off = OffsetW'(a[12:0]);
    end else if (a >= 16'h8000 && a < 16'hC000) begin
      cpu_tgt = TGT_PRGROM;
      cpu_off = prg_low_off;
    end else if (a >= 16'hC000) begin
      cpu_tgt = TGT_PRGROM;
      cpu_off = prg_high_off;
    end else begin
      cpu_tgt = TGT_NONE;
    end
  end

  // PPU map, address already folded to 14 bits
  assign ppu_peek = (item_i.kind == KIND_PPU_PEEK);
  always_comb begin
    ppu_tgt = TGT_VRAM;
    ppu_off = OffsetW'(pa);
    priority if (pa < 14'h2000 && cfg_i.chr_is_ram) begin
      ppu_tgt = TGT_CHRRAM;
    end else if (pa < 14'h1000) begin
      ppu_tgt = TGT_CHRROM;
      ppu_off = chr_low_off;
    end else if (pa < 14'h2000) begin
      ppu_tgt = TGT_CHRROM;
      ppu_off = chr_high_off;
    end else if (pa < 14'h3F00) begin
      if (ppu_peek && pa < 14'h3000) begin
        ppu_off = OffsetW'({2'b10, nt_mir});
      end
    end else begin
      // palette mirrored every 32 bytes
      ppu_off = OffsetW'({9'h1F8, pa[4:0]});
    end
  end

  always_comb begin
    tgt = TGT_NONE;
    off = '0;
    unique case (kind_e'(item_i.kind))
      KIND_CPU_READ: begin
        priority if (a >= 16'h2000 && a < 16'h4000) begin
          tgt = TGT_PPUREG;
          off = OffsetW'(a[2:0]);
        end else if (a == 16'h4016 || a == 16'h4017) begin
          tgt = TGT_CTRL;
          off = OffsetW'(a[0]);
        end else if (a >= 16'h4000 && a <= 16'h4018) begin
          tgt = TGT_APU;
          off = OffsetW'(a[4:0]);
        end else begin
          tgt = cpu_tgt;
          off = cpu_off;
        end
      end
      KIND_CPU_WRITE: begin
        priority if (a >= 16'h2000 && a < 16'h4000) begin
          tgt = TGT_PPUREG;
          off = OffsetW'(a[2:0]);
        end else if (a == 16'h4014) begin
          tgt = TGT_DMA;
        end else if (a == 16'h4016) begin
          tgt = TGT_CTRL;
        end else if (a >= 16'h4000 && a <= 16'h4018) begin
          tgt = TGT_APU;
          off = OffsetW'(a[4:0]);
        end else if (a >= 16'h8000) begin
          tgt = TGT_MAPPER;
          off = OffsetW'(a[14:0]);
        end else begin
          tgt = cpu_tgt;
          off = cpu_off;
        end
      end
      KIND_CPU_PEEK: begin
        tgt = cpu_tgt;
        off = cpu_off;
      end
      KIND_PPU_READ, KIND_PPU_PEEK: begin
        tgt = ppu_tgt;
        off = ppu_off;
      end
      KIND_PPU_WRITE: begin
        // writes to CHR ROM are dropped
        if (pa < 14'h2000 && !cfg_i.chr_is_ram) begin
          tgt = TGT_NONE;
        end else begin
          tgt = ppu_tgt;
          off = ppu_off;
        end
      end
      default: begin
        tgt = TGT_NONE;
      end
    endcase
  end

  assign result_o.target   = tgt;
  assign result_o.offset   = off;
  assign result_o.data_out = (item_i.kind == KIND_CPU_WRITE || item_i.kind == KIND_PPU_WRITE)
                             ? item_i.write_byte : 8'd0;

endmodule

[rtl/cbad_checker.sv]
// Port-level checks for the console bus address decoder, bound to the top level.
module cbad_checker import cbad_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_item_t           out_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // input is stalled only while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.target == TGT_NONE || out_item_o.target == TGT_DMA)
      |-> out_item_o.offset == '0)
    else $error("unmapped or DMA result with nonzero offset");

  a_ppureg_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.target == TGT_PPUREG |-> out_item_o.offset[OffsetW-1:3] == '0)
    else $error("PPU register offset out of range");

  a_ram_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.target == TGT_RAM |-> out_item_o.offset[OffsetW-1:11] == '0)
    else $error("RAM offset outside 2 KB");

endmodule

bind console_bus_address_decoder cbad_checker u_cbad_checker (.*);

[sim/bus_decode_check_pkg.sv]
// Scoreboard package for the console bus address decoder testbench.
`timescale 1ns / 100ps

package bus_decode_check_pkg;
  import cbad_pkg::*;

  localparam int unsigned HeaderBytes = 16;

  // Mirroring codes that leave nametables unmirrored.
  localparam logic [1:0] NT_NONE     = 2'd2;
  localparam logic [1:0] NT_NONE_ALT = 2'd3;

  class decode_scoreboard;
    cfg_t        regs;
    out_item_t   expected_decodes [$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned target_hits [12];

    function new();
      regs = '0;
      regs.prg_rom_units = 8'd1;
      regs.nametable_mode = NT_NONE;
      mismatches = 0;
      results_checked = 0;
      foreach (target_hits[i]) target_hits[i] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_PRG_BANK_LOW:  regs.prg_bank_low = value;
        CFG_PRG_BANK_HIGH: regs.prg_bank_high = value;
        CFG_CHR_BANK_LOW:  regs.chr_bank_low = value;
        CFG_CHR_BANK_HIGH: regs.chr_bank_high = value;
        CFG_CHR_IS_RAM:    regs.chr_is_ram = value[0];
        CFG_PRG_ROM_UNITS: regs.prg_rom_units = value;
        CFG_NT_MODE:       regs.nametable_mode = value[1:0];
        default: ;
      endcase
    endfunction

    // Plain CPU map, also the fall-through for reads and writes.
    function void cpu_map(logic [15:0] a, output target_e tg, output int unsigned off);
      tg = TGT_NONE;
      off = 0;
      if (a < 16'h2000) begin
        tg = TGT_RAM;
        off = 32'(a[10:0]);
      end else if (a < 16'h4000) begin
        tg = TGT_PPUREG;
        off = 32'(a[2:0]);
      end else if (a == 16'h4016) begin
        tg = TGT_CTRL;
      end else if (a < 16'h4018) begin
        tg = TGT_APU;
        off = 32'(a) - 32'h4000;
      end else if (a >= 16'h6000 && a < 16'h8000) begin
        tg = TGT_PRGRAM;
        off = 32'(a) - 32'h6000;
      end else if (a >= 16'h8000 && a < 16'hC000) begin
        tg = TGT_PRGROM;
        off = HeaderBytes + 32'(regs.prg_bank_low) * 32'h4000 + 32'(a) - 32'h8000;
      end else if (a >= 16'hC000) begin
        tg = TGT_PRGROM;
        off = HeaderBytes + 32'(regs.prg_bank_high) * 32'h4000 + 32'(a) - 32'hC000;
      end
    endfunction

    function void ppu_map(logic [15:0] a, bit peek, output target_e tg,
                          output int unsigned off);
      logic [13:0] p;
      int unsigned chr_base;
      int unsigned r;
      p = a[13:0];
      chr_base = HeaderBytes + 32'(regs.prg_rom_units) * 32'h4000;
      if (p < 14'h2000 && regs.chr_is_ram) begin
        tg = TGT_CHRRAM;
        off = 32'(p);
      end else if (p < 14'h1000) begin
        tg = TGT_CHRROM;
        off = chr_base + 32'(regs.chr_bank_low) * 32'h1000 + 32'(p);
      end else if (p < 14'h2000) begin
        tg = TGT_CHRROM;
        off = chr_base + 32'(regs.chr_bank_high) * 32'h1000 + 32'(p) - 32'h1000;
      end else if (p < 14'h3F00) begin
        tg = TGT_VRAM;
        off = 32'(p);
        // mirroring only on peeks, and only in the nametable span
        if (peek && p < 14'h3000) begin
          r = 32'(p) - 32'h2000;
          if (regs.nametable_mode == NT_HORIZONTAL) r = (r / 32'h800) * 32'h800 + r % 32'h400;
          else if (regs.nametable_mode == NT_VERTICAL) r = r % 32'h800;
          off = 32'h2000 + r;
        end
      end else begin
        tg = TGT_VRAM;
        off = 32'h3F00 + 32'(p[4:0]);
      end
    endfunction

    function out_item_t decode_access(in_item_t acc);
      out_item_t   res;
      logic [15:0] a;
      target_e     tg;
      int unsigned off;
      a = acc.bus_address;
      tg = TGT_NONE;
      off = 0;
      res.data_out = 8'h00;
      case (acc.kind)
        KIND_CPU_READ: begin
          if (a >= 16'h2000 && a < 16'h4000) begin
            tg = TGT_PPUREG;
            off = 32'(a[2:0]);
          end else if (a == 16'h4016 || a == 16'h4017) begin
            tg = TGT_CTRL;
            off = 32'(a) - 32'h4016;
          end else if (a >= 16'h4000 && a <= 16'h4018) begin
            tg = TGT_APU;
            off = 32'(a) - 32'h4000;
          end else cpu_map(a, tg, off);
        end
        KIND_CPU_WRITE: begin
          res.data_out = acc.write_byte;
          if (a >= 16'h2000 && a < 16'h4000) begin
            tg = TGT_PPUREG;
            off = 32'(a[2:0]);
          end else if (a == 16'h4014) begin
            tg = TGT_DMA;
          end else if (a == 16'h4016) begin
            tg = TGT_CTRL;
          end else if (a >= 16'h4000 && a <= 16'h4018) begin
            tg = TGT_APU;
            off = 32'(a) - 32'h4000;
          end else if (a >= 16'h8000) begin
            tg = TGT_MAPPER;
            off = 32'(a) - 32'h8000;
          end else cpu_map(a, tg, off);
        end
        KIND_CPU_PEEK: cpu_map(a, tg, off);
        KIND_PPU_READ: ppu_map(a, 1'b0, tg, off);
        KIND_PPU_WRITE: begin
          res.data_out = acc.write_byte;
          // pattern writes without CHR RAM are dropped
          if (!(a[13:0] < 14'h2000 && !regs.chr_is_ram)) ppu_map(a, 1'b0, tg, off);
        end
        KIND_PPU_PEEK: ppu_map(a, 1'b1, tg, off);
        default: ;
      endcase
      res.target = tg;
      res.offset = off[OffsetW-1:0];
      return res;
    endfunction

    function void note_access(in_item_t acc);
      expected_decodes.push_back(decode_access(acc));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_decodes.size() == 0) begin
        $error("result with nothing outstanding: target %0d offset 0x%0h data 0x%0h",
               got.target, got.offset, got.data_out);
        mismatches++;
        return;
      end
      want = expected_decodes.pop_front();
      results_checked++;
      target_hits[want.target]++;
      if (got.target !== want.target) begin
        $error("target: expected %0d, got %0d", want.target, got.target);
        mismatches++;
      end
      if (got.offset !== want.offset) begin
        $error("offset: expected 0x%0h, got 0x%0h", want.offset, got.offset);
        mismatches++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected 0x%0h, got 0x%0h", want.data_out, got.data_out);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_decodes.size();
    endfunction
  endclass

endpackage

[sim/tb.sv]
// Testbench for the console bus address decoder: directed and random bus accesses.
`timescale 1ns / 100ps

module tb;
  import cbad_pkg::*;
  import bus_decode_check_pkg::*;

  // Kind codes that the block must treat as no access.
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
  // Register index past the last register; writes to it are dropped.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 3'd7;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 4;

  // Decode boundaries; some random addresses land up to two bytes either side.
  localparam logic [15:0] BoundaryAddrs [14] = '{
    16'h0000, 16'h0800, 16'h1000, 16'h2000, 16'h3000, 16'h3F00, 16'h4000,
    16'h4014, 16'h4016, 16'h4018, 16'h6000, 16'h8000, 16'hC000, 16'hFFFF
  };

  logic      clk;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  decode_scoreboard sb;

  // Idling knobs, set per phase by the stimulus process.
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  // Long receiver hold-offs: stimulus bumps requests, the receiver serves them.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  int unsigned accesses_sent = 0;
  int unsigned settings_applied = 0;
  int unsigned quiet_cycles = 0;

  console_bus_address_decoder #(
    .HEADER_BYTES(HeaderBytes)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or a long solid hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Both channels are sampled mid-cycle, where everything is settled for the
  // coming edge. Inputs are noted here too, so prediction sees exactly what
  // the block accepted.
  always @(negedge clk) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        sb.note_access(in_item);
        accesses_sent++;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one item, idling first at the current rate, and hold it until taken.
  task automatic send_access(input logic [2:0] kind, input logic [15:0] addr,
                             input logic [7:0] data);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{kind: kind, bus_address: addr, write_byte: data};
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // One register write per edge; the caller drops the enable afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Stop offering, wait for every result, then let the pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Addresses biased toward the interesting parts of both maps.
  function automatic logic [15:0] random_address();
    logic [15:0] addr;
    case ($urandom_range(7))
      0, 1: addr = 16'($urandom);
      2: addr = 16'($urandom_range(16'h4000, 16'h401F));
      3: addr = {2'($urandom), 14'($urandom_range(14'h2000, 14'h2FFF))};
      4: addr = {2'($urandom), 6'h3F, 8'($urandom)};
      default: addr = BoundaryAddrs[$urandom_range(13)] + 16'($urandom_range(4)) - 16'd2;
    endcase
    return addr;
  endfunction

  function automatic cfg_t random_settings(input logic [1:0] mode);
    cfg_t s;
    s.prg_bank_low = 8'($urandom);
    s.prg_bank_high = 8'($urandom);
    s.chr_bank_low = 8'($urandom);
    s.chr_bank_high = 8'($urandom);
    s.chr_is_ram = 1'($urandom);
    s.prg_rom_units = 8'($urandom_range(1, 255));
    s.nametable_mode = mode;
    return s;
  endfunction

  task automatic run_phase(input bit load_regs, input cfg_t s, input int unsigned src,
                           input int unsigned sink, input int unsigned count,
                           input bit pressure);
    logic [2:0] kind;
    if (load_regs) begin
      write_reg(CFG_PRG_BANK_LOW, s.prg_bank_low);
      write_reg(CFG_PRG_BANK_HIGH, s.prg_bank_high);
      write_reg(CFG_CHR_BANK_LOW, s.chr_bank_low);
      write_reg(CFG_CHR_BANK_HIGH, s.chr_bank_high);
      write_reg(CFG_CHR_IS_RAM, {7'd0, s.chr_is_ram});
      write_reg(CFG_PRG_ROM_UNITS, s.prg_rom_units);
      write_reg(CFG_NT_MODE, {6'd0, s.nametable_mode});
      // must change nothing
      write_reg(CFG_UNUSED_IDX, 8'($urandom));
      cfg_we <= 1'b0;
    end
    settings_applied++;
    src_idle_pct = src;
    sink_stall_pct = sink;
    if (pressure) hold_requests++;
    repeat (count) begin
      if ($urandom_range(99) < 3) kind = $urandom_range(1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
      else kind = 3'($urandom_range(5));
      send_access(kind, random_address(), 8'($urandom));
    end
    settle();
  endtask

  initial begin
    string hits_line;
    sb = new();
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed accesses under the reset register values (no mirroring).
    send_access(KIND_CPU_READ,  16'h0000, 8'h00);
    send_access(KIND_CPU_READ,  16'h1FFF, 8'hFF);   // top RAM mirror
    send_access(KIND_CPU_WRITE, 16'h2000, 8'hFF);
    send_access(KIND_CPU_READ,  16'h3FFF, 8'h00);   // last PPU register mirror
    send_access(KIND_CPU_READ,  16'h4014, 8'h00);   // read of DMA port hits APU
    send_access(KIND_CPU_WRITE, 16'h4014, 8'hA5);   // OAM DMA
    send_access(KIND_CPU_READ,  16'h4016, 8'h00);
    send_access(KIND_CPU_READ,  16'h4017, 8'h00);
    send_access(KIND_CPU_WRITE, 16'h4016, 8'h5A);
    send_access(KIND_CPU_WRITE, 16'h4017, 8'h01);   // second pad port is APU on write
    send_access(KIND_CPU_READ,  16'h4018, 8'h00);
    send_access(KIND_CPU_PEEK,  16'h4018, 8'h00);   // hole on peek
    send_access(KIND_CPU_PEEK,  16'h4016, 8'h00);
    send_access(KIND_CPU_READ,  16'h4019, 8'h00);
    send_access(KIND_CPU_WRITE, 16'h5FFF, 8'h80);
    send_access(KIND_CPU_PEEK,  16'h6000, 8'h00);
    send_access(KIND_CPU_READ,  16'h7FFF, 8'h00);
    send_access(KIND_CPU_READ,  16'h8000, 8'h00);
    send_access(KIND_CPU_PEEK,  16'hFFFF, 8'h00);
    send_access(KIND_CPU_WRITE, 16'hC000, 8'h00);   // mapper
    send_access(KIND_PPU_READ,  16'h0000, 8'h00);
    send_access(KIND_PPU_WRITE, 16'h1FFF, 8'hC3);   // dropped: pattern space is ROM
    send_access(KIND_PPU_READ,  16'hFFFF, 8'h00);   // folds to top of palette
    send_access(KIND_PPU_PEEK,  16'h2C00, 8'h00);
    send_access(KIND_PPU_WRITE, 16'h3F20, 8'h7E);   // palette mirror
    send_access(KIND_UNUSED_6,  16'h1234, 8'hFF);
    send_access(KIND_UNUSED_7,  16'hFFFF, 8'hFF);
    run_phase(1'b0, '0, 0, 0, 140, 1'b0);

    // Register extremes first, then random banks under each mirroring mode.
    run_phase(1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h01, NT_HORIZONTAL},
              0, 0, 170, 1'b0);
    run_phase(1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, NT_VERTICAL},
              71, 0, 170, 1'b0);
    // Receiver holds off while the sender keeps offering: the pipe must fill.
    run_phase(1'b1, '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 8'hFF, NT_NONE_ALT},
              0, 71, 170, 1'b1);
    run_phase(1'b1, random_settings(NT_HORIZONTAL), 19, 19, 170, 1'b0);
    run_phase(1'b1, random_settings(NT_VERTICAL), 0, 0, 170, 1'b0);
    run_phase(1'b1, random_settings(NT_NONE), 71, 0, 170, 1'b0);
    run_phase(1'b1, random_settings(2'($urandom)), 0, 71, 170, 1'b0);
    run_phase(1'b1, random_settings(2'($urandom)), 19, 19, 170, 1'b0);

    repeat (8) @(posedge clk);

    hits_line = "";
    foreach (sb.target_hits[i]) hits_line = {hits_line, $sformatf(" %0d", sb.target_hits[i])};
    $display("Covered %0d bus accesses under %0d register settings, %0d results checked.",
             accesses_sent, settings_applied, sb.results_checked);
    $display("Results per target, ram through vram:%s", hits_line);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatching fields", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cbad_pkg.sv
rtl/cbad_decode.sv
rtl/console_bus_address_decoder.sv
rtl/cbad_checker.sv
sim/bus_decode_check_pkg.sv
sim/tb.sv
